/* design/byte_stack_sized_push_pop_defines.svh */
// Assertion macros for the byte stack.
`ifndef BYTE_STACK_SIZED_PUSH_POP_DEFINES_SVH
`define BYTE_STACK_SIZED_PUSH_POP_DEFINES_SVH

`ifndef SYNTHESIS
`define BSSP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BSSP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BSSP_ASSERT_IMP(lbl, ante, cons, msg)
`define BSSP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

/* design/bssp_pkg.sv */
// Types and constants shared by the byte stack modules.
`default_nettype none
package bssp_pkg;

    localparam int STORE_BYTES = 1024;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int PTR_W       = ADDR_W + 1;
    localparam int SIZE_W      = 4;
    localparam int MAX_SIZE    = 8;
    localparam int DATA_W      = 64;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_FINISH
    } ctrl_state_t;

    typedef struct packed {
        op_t                 operation;
        logic [SIZE_W-1:0]   size_bytes;
        logic [DATA_W-1:0]   push_value;
    } in_word_t;

    typedef struct packed {
        logic [DATA_W-1:0]   pop_value;
        status_t             status;
        logic [PTR_W-1:0]    fill_bytes;
    } out_word_t;

    typedef struct packed {
        logic load_req;
        logic step;
        logic load_out;
    } ctrl_cmd_t;

    typedef struct packed {
        logic more;
        logic pend;
        logic out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

/* design/bssp_dpath.sv */
// Datapath: byte store, top pointer, request registers and output register.
`default_nettype none
module bssp_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire bssp_pkg::in_word_t  in_data,
    input  wire bssp_pkg::ctrl_cmd_t cmd,
    output bssp_pkg::dp_stat_t       stat,
    input  wire logic                out_ready,
    output logic                     out_valid,
    output bssp_pkg::out_word_t      out_data
);

    logic [7:0] mem [bssp_pkg::STORE_BYTES];

    logic [bssp_pkg::PTR_W-1:0]  top_reg, top_next;
    logic [bssp_pkg::SIZE_W-1:0] cnt_reg, cnt_next;
    logic                        rd_pend_reg;
    logic                        out_valid_reg;
    bssp_pkg::op_t               op_reg;
    bssp_pkg::status_t           status_reg;
    logic [bssp_pkg::DATA_W-1:0] val_reg, acc_reg;
    logic [7:0]                  rdata_reg;
    bssp_pkg::out_word_t         out_reg;

    logic [bssp_pkg::SIZE_W-1:0] size_sat;
    logic [bssp_pkg::PTR_W:0]    push_end;
    logic [bssp_pkg::PTR_W-1:0]  size_ext;
    logic [bssp_pkg::PTR_W-1:0]  top_dec;
    logic [bssp_pkg::ADDR_W-1:0] addr;
    bssp_pkg::status_t           req_status;

    always_comb
    begin
        size_sat = (in_data.size_bytes > bssp_pkg::SIZE_W'(bssp_pkg::MAX_SIZE))
                 ? bssp_pkg::SIZE_W'(bssp_pkg::MAX_SIZE) : in_data.size_bytes;
        size_ext = bssp_pkg::PTR_W'(size_sat);
        push_end = {1'b0, top_reg} + (bssp_pkg::PTR_W+1)'(size_sat);
        top_dec  = top_reg - bssp_pkg::PTR_W'(1);
        // empty is checked ahead of the size check
        priority if (in_data.operation == bssp_pkg::OP_PUSH)
            req_status = (push_end > (bssp_pkg::PTR_W+1)'(bssp_pkg::STORE_BYTES))
                       ? bssp_pkg::ST_OVERFLOW : bssp_pkg::ST_OK;
        else if (top_reg == '0)
            req_status = bssp_pkg::ST_EMPTY;
        else if (top_reg < size_ext)
            req_status = bssp_pkg::ST_UNDERFLOW;
        else
            req_status = bssp_pkg::ST_OK;
    end

    assign addr = (op_reg == bssp_pkg::OP_PUSH) ? top_reg[bssp_pkg::ADDR_W-1:0]
                                                : top_dec[bssp_pkg::ADDR_W-1:0];

    always_comb
    begin
        top_next = top_reg;
        cnt_next = cnt_reg;
        if (cmd.load_req)
            cnt_next = (req_status == bssp_pkg::ST_OK) ? size_sat : '0;
        else if (cmd.step)
        begin
            cnt_next = cnt_reg - bssp_pkg::SIZE_W'(1);
            top_next = (op_reg == bssp_pkg::OP_PUSH) ? top_reg + bssp_pkg::PTR_W'(1)
                                                     : top_dec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            top_reg       <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            top_reg     <= top_next;
            cnt_reg     <= cnt_next;
            rd_pend_reg <= cmd.step && (op_reg == bssp_pkg::OP_POP);
            if (cmd.load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // single-port store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.step && op_reg == bssp_pkg::OP_PUSH)
            mem[addr] <= val_reg[7:0];
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            op_reg     <= in_data.operation;
            status_reg <= req_status;
            val_reg    <= in_data.push_value;
            acc_reg    <= '0;
        end
        else
        begin
            if (cmd.step)
                val_reg <= val_reg >> 8;
            // first byte read is the most recent one: it ends up on top
            if (rd_pend_reg)
                acc_reg <= {acc_reg[bssp_pkg::DATA_W-9:0], rdata_reg};
        end
        if (cmd.load_out)
        begin
            out_reg.pop_value  <= acc_reg;
            out_reg.status     <= status_reg;
            out_reg.fill_bytes <= top_reg;
        end
    end

    assign stat.more     = (cnt_reg != '0);
    assign stat.pend     = rd_pend_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_data      = out_reg;

endmodule
`default_nettype wire

/* design/bssp_ctrl.sv */
// Controller: sequences one request word through the datapath.
`default_nettype none
module bssp_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bssp_pkg::dp_stat_t  stat,
    output bssp_pkg::ctrl_cmd_t      cmd
);

    bssp_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bssp_pkg::S_IDLE:
                if (in_valid)
                    state_next = bssp_pkg::S_RUN;
            bssp_pkg::S_RUN:
                if (!stat.more && !stat.pend)
                    state_next = bssp_pkg::S_FINISH;
            bssp_pkg::S_FINISH:
                if (stat.out_free)
                    state_next = bssp_pkg::S_IDLE;
            default:
                state_next = bssp_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd.load_req = 1'b0;
        cmd.step     = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            bssp_pkg::S_IDLE:
            begin
                in_ready     = 1'b1;
                cmd.load_req = in_valid;
            end
            bssp_pkg::S_RUN:
                cmd.step = stat.more;
            bssp_pkg::S_FINISH:
                cmd.load_out = stat.out_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bssp_pkg::S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule
`default_nettype wire

/* design/byte_stack_sized_push_pop.sv */
// Top level of the byte-wide LIFO stack with sized push and pop.
//   channel   direction   handshake              word
//   in        input       in_valid / in_ready    in_word_t  (operation, size, value)
//   out       output      out_valid / out_ready  out_word_t (value, status, fill)
// One byte moves per cycle through the single-port store. A refused or zero-size word
// skips the byte moves. One word is worked at a time.
// The result sits in an output register, so the next word is taken while it waits.
// Reset clears the top pointer and the controller; the store needs no clearing.
`default_nettype none
`include "byte_stack_sized_push_pop_defines.svh"
module byte_stack_sized_push_pop (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire bssp_pkg::in_word_t in_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bssp_pkg::out_word_t     out_data
);

    bssp_pkg::ctrl_cmd_t cmd;
    bssp_pkg::dp_stat_t  stat;

    bssp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bssp_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    `BSSP_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second word taken while busy")
    `BSSP_ASSERT_IMP(a_fill_bound, out_valid, out_data.fill_bytes <= bssp_pkg::PTR_W'(bssp_pkg::STORE_BYTES), "fill beyond store size")
    `BSSP_ASSERT_IMP(a_refused_zero, out_valid && out_data.status != bssp_pkg::ST_OK, out_data.pop_value == '0, "refused word carries a value")
    `BSSP_ASSERT_IMP(a_empty_fill, out_valid && out_data.status == bssp_pkg::ST_EMPTY, out_data.fill_bytes == '0, "empty status with bytes held")

endmodule
`default_nettype wire
